// ----- src/xsf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xsf_pkg: shared types and constants for the XOR sprite frame buffer
// Display geometry, field widths, item codes and sequencer states.
// ----------------------------------------------------------------------------
package xsf_pkg;

    // Display geometry: width 8..64, height 8..32
    localparam int DISPLAY_WIDTH  = 64;
    localparam int DISPLAY_HEIGHT = 32;

    // Field widths of the channel words
    localparam int KIND_W     = 2;
    localparam int SPRITE_W   = 8;
    localparam int POS_W      = 8;
    localparam int SEL_W      = 5;
    localparam int ROW_BITS_W = 64;

    // Internal index widths
    localparam int COL_W  = $clog2(DISPLAY_WIDTH);
    localparam int LINE_W = $clog2(DISPLAY_HEIGHT);

    // Modulo reduction by restoring compare-subtract: the smallest modulus
    // is 8, so an 8-bit value needs multiples shifted by 4 down to 0.
    localparam int MIN_MODULUS = 8;
    localparam int RED_STEPS   = POS_W - $clog2(MIN_MODULUS);
    localparam int STEP_W      = $clog2(RED_STEPS);
    localparam int MOD_MAX     = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH
                                                                  : DISPLAY_HEIGHT;
    localparam int RED_W       = $clog2(MOD_MAX + 1) + RED_STEPS - 1;

    // Last pixel index of a sprite row
    localparam int PIX_W = $clog2(SPRITE_W);
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(SPRITE_W - 1);

    typedef logic [RED_W-1:0] red_t;

    // Input item codes
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Result codes
    localparam logic RES_COLLISION = 1'b0;
    localparam logic RES_ROW       = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_X,
        S_RED_Y,
        S_RED_SEL,
        S_RD,
        S_LOAD,
        S_PIX,
        S_WR,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

// ----- src/xsf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xsf_if: valid/ready channels of the XOR sprite frame buffer
// Item channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface xsf_in_if;
    logic                         valid;
    logic                         ready;
    logic [xsf_pkg::KIND_W-1:0]   kind;
    logic [xsf_pkg::SPRITE_W-1:0] sprite_row;
    logic [xsf_pkg::POS_W-1:0]    x_pos;
    logic [xsf_pkg::POS_W-1:0]    y_pos;
    logic                         first_row;
    logic                         last_row;
    logic [xsf_pkg::SEL_W-1:0]    row_select;

    modport source (
        output valid, kind, sprite_row, x_pos, y_pos, first_row, last_row, row_select,
        input  ready
    );
    modport sink (
        input  valid, kind, sprite_row, x_pos, y_pos, first_row, last_row, row_select,
        output ready
    );
endinterface

interface xsf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           result_kind;
    logic                           collision;
    logic [xsf_pkg::ROW_BITS_W-1:0] row_bits;

    modport source (
        output valid, result_kind, collision, row_bits,
        input  ready
    );
    modport sink (
        input  valid, result_kind, collision, row_bits,
        output ready
    );
endinterface
`default_nettype wire

// ----- src/xor_sprite_framebuffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer: one-bit frame store drawn with XORed sprite rows
// A draw row runs the read, load, pixel and write states, a first row after
// reducing x and y; a read reduces its row number, reads and replies; a clear
// is done on accept. One item at a time: the next item is taken only after
// the previous finishes; the 8-pixel loop and 5-step reduction share one unit.
// Reset: asynchronous; all rows read as cleared at once through row valid bits.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer (
    input  logic       clk,
    input  logic       rst_n,
    xsf_in_if.sink     din,
    xsf_out_if.source  dout
);
    import xsf_pkg::*;

    // Sequencer
    state_t state_reg, state_next;

    // Latched item
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SPRITE_W-1:0] sprite_reg, sprite_next;
    logic [POS_W-1:0]    y_reg, y_next;
    logic                last_reg, last_next;

    // Reduction and pixel loop counters
    red_t                val_reg, val_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;

    // Drawing state
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    pcol_reg, pcol_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [LINE_W-1:0]   addr_reg, addr_next;
    logic                hit_reg, hit_next;
    logic [DISPLAY_WIDTH-1:0] word_reg, word_next;

    // Frame store: a row is zero until written after reset or clear
    logic [DISPLAY_WIDTH-1:0] mem [DISPLAY_HEIGHT];
    logic [DISPLAY_HEIGHT-1:0] row_valid_reg;
    logic [DISPLAY_WIDTH-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [LINE_W-1:0]   rd_addr;
    logic                mem_we;
    logic                valid_clear;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic                out_coll_reg, out_coll_next;
    logic [ROW_BITS_W-1:0] out_row_reg, out_row_next;
    logic                out_free;

    // Shared compare-subtract unit
    red_t                unit_val;
    red_t                unit_mod;
    red_t                unit_out;

    logic                in_fire;
    logic                step_done;

    localparam red_t MOD_COL  = red_t'(DISPLAY_WIDTH);
    localparam red_t MOD_LINE = red_t'(DISPLAY_HEIGHT);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(RED_STEPS - 1);

    assign din.ready  = (state_reg == S_IDLE);
    assign in_fire    = din.valid && din.ready;
    assign out_free   = !out_valid_reg || dout.ready;
    assign step_done  = (step_reg == '0);
    assign rd_addr    = (kind_reg == KIND_DRAW) ? line_reg : addr_reg;

    assign dout.valid       = out_valid_reg;
    assign dout.result_kind = out_kind_reg;
    assign dout.collision   = out_coll_reg;
    assign dout.row_bits    = out_row_reg;

    xsf_modsub u_modsub (
        .value   (unit_val),
        .modulus (unit_mod),
        .result  (unit_out)
    );

    // Operand select for the shared unit: reduction steps use shifted
    // multiples of the modulus; column and line advance use the modulus itself.
    always_comb
    begin
        case (state_reg)
            S_RED_X:
            begin
                unit_val = val_reg;
                unit_mod = MOD_COL << step_reg;
            end
            S_RED_Y, S_RED_SEL:
            begin
                unit_val = val_reg;
                unit_mod = MOD_LINE << step_reg;
            end
            S_PIX:
            begin
                unit_val = red_t'(pcol_reg) + red_t'(1);
                unit_mod = MOD_COL;
            end
            S_WR:
            begin
                unit_val = red_t'(line_reg) + red_t'(1);
                unit_mod = MOD_LINE;
            end
            default:
            begin
                unit_val = val_reg;
                unit_mod = MOD_COL;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (din.kind)
                        KIND_DRAW: state_next = din.first_row ? S_RED_X : S_RD;
                        KIND_READ: state_next = S_RED_SEL;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RED_X:
            begin
                if (step_done)
                    state_next = S_RED_Y;
            end
            S_RED_Y, S_RED_SEL:
            begin
                if (step_done)
                    state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = (kind_reg == KIND_DRAW) ? S_PIX : S_RESP;
            end
            S_PIX:
            begin
                if (pix_reg == PIX_LAST)
                    state_next = S_WR;
            end
            S_WR:
            begin
                if (!last_reg || out_free)
                    state_next = S_IDLE;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        kind_next      = kind_reg;
        sprite_next    = sprite_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        step_next      = step_reg;
        pix_next       = pix_reg;
        col_next       = col_reg;
        pcol_next      = pcol_reg;
        line_next      = line_reg;
        addr_next      = addr_reg;
        hit_next       = hit_reg;
        word_next      = word_reg;
        mem_we         = 1'b0;
        valid_clear    = 1'b0;
        out_valid_next = out_valid_reg && !dout.ready;
        out_kind_next  = out_kind_reg;
        out_coll_next  = out_coll_reg;
        out_row_next   = out_row_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // Latch the item; seed the reduction with x or the row number
                    kind_next   = din.kind;
                    sprite_next = din.sprite_row;
                    y_next      = din.y_pos;
                    last_next   = din.last_row;
                    step_next   = STEP_FIRST;
                    val_next    = (din.kind == KIND_DRAW) ? red_t'(din.x_pos)
                                                          : red_t'(din.row_select);
                    if (din.kind == KIND_CLEAR)
                        valid_clear = 1'b1;
                end
            end
            S_RED_X:
            begin
                val_next  = unit_out;
                step_next = step_reg - STEP_W'(1);
                if (step_done)
                begin
                    // Start column done; reduce y next
                    col_next  = unit_out[COL_W-1:0];
                    val_next  = red_t'(y_reg);
                    step_next = STEP_FIRST;
                end
            end
            S_RED_Y:
            begin
                val_next  = unit_out;
                step_next = step_reg - STEP_W'(1);
                if (step_done)
                begin
                    line_next = unit_out[LINE_W-1:0];
                    hit_next  = 1'b0;
                end
            end
            S_RED_SEL:
            begin
                val_next  = unit_out;
                step_next = step_reg - STEP_W'(1);
                if (step_done)
                    addr_next = unit_out[LINE_W-1:0];
            end
            S_LOAD:
            begin
                // Start the pixel walk at the start column; keep that column
                word_next = rd_valid_reg ? rd_data_reg : '0;
                pix_next  = '0;
                pcol_next = col_reg;
            end
            S_PIX:
            begin
                // One pixel per cycle, leftmost first; column wraps in the unit
                pix_next  = pix_reg + PIX_W'(1);
                pcol_next = unit_out[COL_W-1:0];
                if (sprite_reg[PIX_LAST - pix_reg])
                begin
                    hit_next            = hit_reg | word_reg[pcol_reg];
                    word_next[pcol_reg] = ~word_reg[pcol_reg];
                end
            end
            S_WR:
            begin
                // Hold until the result register is free when a report is due
                if (!last_reg || out_free)
                begin
                    mem_we    = 1'b1;
                    line_next = unit_out[LINE_W-1:0];
                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = RES_COLLISION;
                        out_coll_next  = hit_reg;
                        out_row_next   = '0;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_ROW;
                    out_coll_next  = 1'b0;
                    out_row_next   = ROW_BITS_W'(word_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            line_reg      <= '0;
            hit_reg       <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            hit_reg       <= hit_next;
            if (valid_clear)
                row_valid_reg <= '0;
            else if (mem_we)
                row_valid_reg[line_reg] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sprite_reg   <= sprite_next;
        y_reg        <= y_next;
        last_reg     <= last_next;
        val_reg      <= val_next;
        step_reg     <= step_next;
        pix_reg      <= pix_next;
        pcol_reg     <= pcol_next;
        addr_reg     <= addr_next;
        word_reg     <= word_next;
        out_kind_reg <= out_kind_next;
        out_coll_reg <= out_coll_next;
        out_row_reg  <= out_row_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[line_reg] <= word_reg;
        if (state_reg == S_RD)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/xsf_modsub.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xsf_modsub: shared compare-subtract unit
// Subtract the modulus when the value reaches it; one reduction step.
// ----------------------------------------------------------------------------
module xsf_modsub (
    input  xsf_pkg::red_t value,
    input  xsf_pkg::red_t modulus,
    output xsf_pkg::red_t result
);
    import xsf_pkg::*;

    red_t diff;

    assign diff   = value - modulus;
    assign result = (value >= modulus) ? diff : value;

endmodule
`default_nettype wire

// ----- tb/xor_sprite_framebuffer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_tb: self-checking bench for the XOR sprite frame buffer
// A queue of draw, clear and read words feeds a bursty driver. A shadow frame
// store predicts every collision report and row read, and the monitor checks
// each returned word field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_tb;

    import xsf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_WORDS = 1000;
    // Slowest word is a first sprite row; allow for it plus sender gaps and
    // receiver stalls, several times over.
    localparam int RUN_LIMIT    = 400000;
    // The slowest item is a first sprite row; let trailing no-result words finish.
    localparam int DRAIN_CYCLES = 60;
    // One long receiver hold-off, so the block fills up and stalls its input.
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 600;

    // Kind value that the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [SPRITE_W-1:0] sprite_row;
        logic [POS_W-1:0]    x_pos;
        logic [POS_W-1:0]    y_pos;
        logic                first_row;
        logic                last_row;
        logic [SEL_W-1:0]    row_select;
    } frame_cmd_t;

    typedef struct {
        logic                  result_kind;
        logic                  collision;
        logic [ROW_BITS_W-1:0] row_bits;
    } frame_report_t;

    logic clk = 1'b0;
    logic rst_n;

    xsf_in_if  din_if ();
    xsf_out_if dout_if ();

    xor_sprite_framebuffer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    always
    begin
        #(CLK_PERIOD / 2);
        clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow frame store: the expected contents of the display and the
    // sprite cursor, updated as each word is taken by the block.
    // ------------------------------------------------------------------------
    logic [ROW_BITS_W-1:0] shadow_rows [DISPLAY_HEIGHT] = '{default: '0};
    int                    shadow_column = 0;
    int                    shadow_line   = 0;
    logic                  shadow_hit    = 1'b0;

    frame_cmd_t    frame_cmds [$];          // words still to be offered
    frame_report_t predicted_reports [$];   // replies the block still owes

    int words_taken    = 0;
    int counted_words  = 0;
    int mismatch_count = 0;
    int run_cycles     = 0;

    // Apply one accepted word to the shadow store and queue its reply, if any.
    task automatic apply_frame_word(input frame_cmd_t cmd);
        logic [ROW_BITS_W-1:0] row_word;
        int                    pix;
        int                    col;
        case (cmd.kind)
            KIND_DRAW:
            begin
                // A first row latches the cursor and restarts collision tracking.
                if (cmd.first_row)
                begin
                    shadow_column = cmd.x_pos % DISPLAY_WIDTH;
                    shadow_line   = cmd.y_pos % DISPLAY_HEIGHT;
                    shadow_hit    = 1'b0;
                end
                row_word = shadow_rows[shadow_line];
                // Bit 7 of the sprite byte lands on the start column; wrap right.
                for (pix = 0; pix < SPRITE_W; pix++)
                begin
                    if (cmd.sprite_row[SPRITE_W-1-pix])
                    begin
                        col = (shadow_column + pix) % DISPLAY_WIDTH;
                        if (row_word[col])
                            shadow_hit = 1'b1;
                        row_word[col] = ~row_word[col];
                    end
                end
                shadow_rows[shadow_line] = row_word;
                shadow_line = (shadow_line + 1) % DISPLAY_HEIGHT;
                if (cmd.last_row)
                    predicted_reports.push_back(
                        frame_report_t'{RES_COLLISION, shadow_hit, '0});
            end
            KIND_CLEAR:
            begin
                // Clear wipes pixels only; cursor and collision flag survive.
                foreach (shadow_rows[r])
                    shadow_rows[r] = '0;
            end
            KIND_READ:
            begin
                predicted_reports.push_back(frame_report_t'{RES_ROW, 1'b0,
                    shadow_rows[cmd.row_select % DISPLAY_HEIGHT]});
            end
            default:
            begin
                // Unused kind: the block drops the word without a reply.
            end
        endcase
    endtask

    // Append one word to the send queue; ignored kinds do not count.
    task automatic queue_word(input logic [KIND_W-1:0] k, input int sprite, input int x,
                              input int y, input bit first, input bit last,
                              input int sel);
        frame_cmd_t cmd;
        cmd.kind       = k;
        cmd.sprite_row = SPRITE_W'(sprite);
        cmd.x_pos      = POS_W'(x);
        cmd.y_pos      = POS_W'(y);
        cmd.first_row  = first;
        cmd.last_row   = last;
        cmd.row_select = SEL_W'(sel);
        frame_cmds.push_back(cmd);
        if (k != KIND_UNUSED)
            counted_words++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued words in bursts of random length with random gaps.
    // Record each word in the shadow store at the edge where it is taken.
    // ------------------------------------------------------------------------
    frame_cmd_t taken_cmd;
    frame_cmd_t next_cmd;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_if.valid      <= 1'b0;
            din_if.kind       <= KIND_DRAW;
            din_if.sprite_row <= '0;
            din_if.x_pos      <= '0;
            din_if.y_pos      <= '0;
            din_if.first_row  <= 1'b0;
            din_if.last_row   <= 1'b0;
            din_if.row_select <= '0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                taken_cmd.kind       = din_if.kind;
                taken_cmd.sprite_row = din_if.sprite_row;
                taken_cmd.x_pos      = din_if.x_pos;
                taken_cmd.y_pos      = din_if.y_pos;
                taken_cmd.first_row  = din_if.first_row;
                taken_cmd.last_row   = din_if.last_row;
                taken_cmd.row_select = din_if.row_select;
                apply_frame_word(taken_cmd);
                words_taken++;
            end
            // Hold an offered word until the block takes it.
            if (!din_if.valid || din_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    din_if.valid <= 1'b0;
                end
                else if (frame_cmds.size() != 0)
                begin
                    next_cmd = frame_cmds.pop_front();
                    din_if.kind       <= next_cmd.kind;
                    din_if.sprite_row <= next_cmd.sprite_row;
                    din_if.x_pos      <= next_cmd.x_pos;
                    din_if.y_pos      <= next_cmd.y_pos;
                    din_if.first_row  <= next_cmd.first_row;
                    din_if.last_row   <= next_cmd.last_row;
                    din_if.row_select <= next_cmd.row_select;
                    din_if.valid      <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    // End of burst: pick the next burst and its gap; a quarter
                    // of the bursts run back to back.
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                               : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    din_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a 32-bit pattern redrawn each lap, mixing clear
    // runs, light, even and heavy stalling; once hold off for a long stretch.
    // ------------------------------------------------------------------------
    logic [31:0] stall_pattern = '1;
    logic [4:0]  pattern_pos   = '0;
    int          rx_cycles     = 0;
    int          hold_left     = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                hold_left--;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                if (pattern_pos == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_pattern = '1;
                        1:       stall_pattern = $urandom;
                        2:       stall_pattern = $urandom | $urandom;
                        default: stall_pattern = $urandom & $urandom;
                    endcase
                end
                dout_if.ready <= stall_pattern[pattern_pos];
                pattern_pos++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each returned word with the oldest predicted reply.
    // ------------------------------------------------------------------------
    frame_report_t want;

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("unexpected word: result_kind %0d collision %0d row_bits %h",
                       dout_if.result_kind, dout_if.collision, dout_if.row_bits);
                mismatch_count++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (dout_if.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, dout_if.result_kind);
                    mismatch_count++;
                end
                if (dout_if.collision !== want.collision)
                begin
                    $error("collision: expected %0d, got %0d",
                           want.collision, dout_if.collision);
                    mismatch_count++;
                end
                if (dout_if.row_bits !== want.row_bits)
                begin
                    $error("row_bits: expected %h, got %h",
                           want.row_bits, dout_if.row_bits);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int total_words;
        int pick;
        int rows;
        int sx;
        int sy;
        bit broken;

        // Hold reset from the start; the driver and receiver park their outputs.
        rst_n = 1'b0;

        // Directed part.
        // Read a row straight out of reset: all pixels clear.
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 0);
        // Draw with no first row: cursor at column zero, line zero.
        queue_word(KIND_DRAW, 255, 255, 255, 0, 1, 31);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 0);
        // Single-row sprite, first and last at once, erasing every pixel.
        queue_word(KIND_DRAW, 255, 0, 0, 1, 1, 0);
        // Start at the far corner: both column and line wrap.
        queue_word(KIND_DRAW, 8'h81, 255, 255, 1, 0, 0);
        queue_word(KIND_DRAW, 255, 0, 0, 0, 1, 0);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 31);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 0);
        // Empty sprite row draws nothing.
        queue_word(KIND_DRAW, 0, 17, 100, 1, 1, 0);
        // Unused kind with every field at its maximum.
        queue_word(KIND_UNUSED, 255, 255, 255, 1, 1, 31);
        queue_word(KIND_READ, 255, 255, 255, 1, 1, 0);
        // Clear, then check the store is blank.
        queue_word(KIND_CLEAR, 255, 255, 255, 1, 1, 31);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 31);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 0);
        // Three-row sprite, then redraw its first row to force a collision.
        queue_word(KIND_DRAW, 8'hAA, 5, 10, 1, 0, 0);
        queue_word(KIND_DRAW, 8'h55, 0, 0, 0, 0, 0);
        queue_word(KIND_DRAW, 8'hF0, 0, 0, 0, 1, 0);
        queue_word(KIND_DRAW, 8'hAA, 5, 10, 1, 1, 0);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 10);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 11);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 12);
        // Positions at multiples of the display size reduce to zero.
        queue_word(KIND_DRAW, 8'h01, 128, 32, 1, 1, 0);
        queue_word(KIND_READ, 0, 0, 0, 0, 0, 0);

        // Random part: mostly whole sprites with random content, plus reads,
        // rare clears, ignored kinds and broken draw sequences.
        while (counted_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                rows   = $urandom_range(1, 15);
                sx     = $urandom_range(0, 255);
                sy     = $urandom_range(0, 255);
                broken = ($urandom_range(0, 9) == 0);
                for (int r = 0; r < rows; r++)
                begin
                    queue_word(KIND_DRAW, $urandom_range(0, 255),
                               (r == 0) ? sx : $urandom_range(0, 255),
                               (r == 0) ? sy : $urandom_range(0, 255),
                               r == 0, (r == rows - 1) && !broken,
                               $urandom_range(0, 31));
                end
            end
            else if (pick < 80)
            begin
                queue_word(KIND_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 31));
            end
            else if (pick < 83)
            begin
                queue_word(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 31));
            end
            else if (pick < 88)
            begin
                queue_word(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 31));
            end
            else
            begin
                queue_word(KIND_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 31));
            end
        end
        total_words = frame_cmds.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken, every reply to arrive, then drain.
        while (words_taken != total_words)
            @(posedge clk);
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: end a run that hangs.
    initial
    begin
        while (run_cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            run_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
